/* rtl/egas_pkg.sv */
// shared types, constants and codes for the epsilon-greedy action selector
package egas_pkg;

    localparam int NUM_STATES   = 16;
    localparam int NUM_ACTIONS  = 8;
    localparam int ROW_W        = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int COL_W        = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int CNT_W        = COL_W + 1;
    localparam int TABLE_DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W       = ROW_W + COL_W;
    localparam int VALUE_W      = 32;

    localparam int EPS_W        = 7;
    localparam int AC_W         = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS = CFG_IDX_W'(1);

    localparam logic [EPS_W-1:0] EPSILON_RESET = EPS_W'(20);
    localparam logic [AC_W-1:0]  ACTIONS_RESET = AC_W'(8);

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // iterative remainder unit: dividend consumed a few bits per cycle
    localparam int RAND_W     = 15;
    localparam int DIV_W      = 7;
    localparam int MOD_STEP   = 3;
    localparam int MOD_STEPS  = RAND_W / MOD_STEP;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS + 1);
    localparam logic [DIV_W-1:0] PERCENT_BASE = DIV_W'(100);

    // reciprocal of the percent base, exact quotient for any 15-bit word
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_PERCENT = RECIP_W'(5243);

    typedef struct packed {
        logic                kind;
        logic [3:0]          state_index;
        logic [2:0]          action_index;
        logic signed [31:0]  q_value;
        logic [RAND_W-1:0]   rand_explore;
        logic [RAND_W-1:0]   rand_pick;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic       explored;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } t_mod_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_OUT
    } t_state;

endpackage

/* rtl/egas_ram.sv */
// generic single-write, single-read ram with registered read data
module egas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/egas_mod.sv */
// iterative remainder unit, a few dividend bits per cycle
module egas_mod import egas_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [RAND_W-1:0]    r_num;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [RAND_W-1:0]    n_num;
    logic [DIV_W-1:0]     n_rem;

    always_comb begin
        logic [DIV_W:0]    rem_t;
        logic [RAND_W-1:0] num_t;
        rem_t = {1'b0, r_rem};
        num_t = r_num;
        for (int j = 0; j < MOD_STEP; j++) begin
            rem_t = {rem_t[DIV_W-1:0], num_t[RAND_W-1]};
            num_t = num_t << 1;
            if (rem_t >= {1'b0, r_div}) begin
                rem_t = rem_t - {1'b0, r_div};
            end
        end
        n_num = num_t;
        n_rem = rem_t[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= MOD_CNT_W'(MOD_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - MOD_CNT_W'(1);
            if (r_cnt == MOD_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

/* rtl/epsilon_greedy_action_select.sv */
// epsilon-greedy action selector: value table in ram, row scan, remainder-based pick
// a write item goes straight into the ram and the block is ready again the next cycle
// a select item runs a row scan of one ram read per action in use, then a remainder pass
// that picks the action, before the result is offered
// the next input is taken once the result sits in the output register
// synchronous reset: per-entry valid bits cleared so the table reads zero, control registers to defaults
module epsilon_greedy_action_select import egas_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                    r_state;
    t_state                    n_state;
    logic [EPS_W-1:0]          r_epsilon;
    logic [AC_W-1:0]           r_action_count;
    logic [TABLE_DEPTH-1:0]    r_vld;
    logic                      r_rd_vld;
    logic [ROW_W-1:0]          r_row;
    logic [RAND_W-1:0]         r_pick;
    logic [CNT_W-1:0]          r_issue;
    logic                      r_data_vld;
    logic [COL_W-1:0]          r_data_col;
    logic                      r_scan_done;
    logic signed [VALUE_W-1:0] r_best;
    logic [COL_W-1:0]          r_ties [NUM_ACTIONS];
    logic [CNT_W-1:0]          r_tie_n;
    logic                      r_explore;
    t_out_item                 r_res;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic                      accept;
    logic                      is_select;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] scan_val;
    logic [CNT_W-1:0]          used_n;
    logic [RAND_W+RECIP_W-1:0] exp_prod;
    logic [RAND_W+RECIP_W-RECIP_SHIFT-1:0] exp_quo;
    logic [RAND_W-1:0]         exp_diff;
    logic                      explore_hit;
    logic                      decide;
    logic                      out_load;
    logic [COL_W-1:0]          pick_idx;
    t_mod_req                  mod_req;
    t_mod_rsp                  mod_rsp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign is_select   = (i_in_item.kind == KIND_SELECT);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_action_count == '0) begin
            used_n = CNT_W'(1);
        end else if (32'(r_action_count) > NUM_ACTIONS) begin
            used_n = CNT_W'(NUM_ACTIONS);
        end else begin
            used_n = CNT_W'(r_action_count);
        end
    end

    // explore residue by reciprocal multiplication
    assign exp_prod    = (RAND_W+RECIP_W)'(i_in_item.rand_explore)
                         * (RAND_W+RECIP_W)'(RECIP_PERCENT);
    assign exp_quo     = exp_prod[RAND_W+RECIP_W-1:RECIP_SHIFT];
    assign exp_diff    = i_in_item.rand_explore
                         - RAND_W'(exp_quo) * RAND_W'(PERCENT_BASE);
    assign explore_hit = (exp_diff[DIV_W-1:0] < r_epsilon);

    assign ram_we    = accept && !is_select
                       && (32'(i_in_item.action_index) < NUM_ACTIONS);
    assign ram_waddr = {i_in_item.state_index[ROW_W-1:0],
                        i_in_item.action_index[COL_W-1:0]};
    assign scan_val    = r_rd_vld ? $signed(ram_rdata) : '0;
    assign decide      = (r_state == S_SCAN) && r_scan_done;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign pick_idx    = mod_rsp.rem[COL_W-1:0];

    egas_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_item.q_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    egas_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_select) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (decide) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (mod_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ram read and remainder unit control
    always_comb begin
        ram_re           = 1'b0;
        ram_raddr        = {r_row, r_issue[COL_W-1:0]};
        mod_req.start    = 1'b0;
        mod_req.dividend = r_pick;
        mod_req.divisor  = PERCENT_BASE;
        case (r_state)
            S_IDLE: begin
                ram_re    = accept && is_select;
                ram_raddr = {i_in_item.state_index[ROW_W-1:0], COL_W'(0)};
            end
            S_SCAN: begin
                ram_re        = (r_issue < used_n);
                mod_req.start = decide;
                if (r_explore) begin
                    mod_req.divisor = DIV_W'(used_n);
                end else begin
                    mod_req.divisor = DIV_W'(r_tie_n);
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_epsilon      <= EPSILON_RESET;
            r_action_count <= ACTIONS_RESET;
            r_vld          <= '0;
            r_issue        <= '0;
            r_data_vld     <= 1'b0;
            r_scan_done    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EPSILON: r_epsilon      <= i_cfg_data[EPS_W-1:0];
                    CFG_ACTIONS: r_action_count <= i_cfg_data[AC_W-1:0];
                    default:     r_epsilon      <= r_epsilon;
                endcase
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (r_state == S_IDLE) begin
                r_issue     <= CNT_W'(1);
                r_data_vld  <= accept && is_select;
                r_scan_done <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_data_vld <= (r_issue < used_n);
                if (r_issue < used_n) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
                if (r_data_vld && (CNT_W'(r_data_col) == used_n - CNT_W'(1))) begin
                    r_scan_done <= 1'b1;
                end
            end else begin
                r_data_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[ram_raddr];
        if (accept && is_select) begin
            r_row     <= i_in_item.state_index[ROW_W-1:0];
            r_pick    <= i_in_item.rand_pick;
            r_explore <= explore_hit;
        end
        if (r_state == S_IDLE) begin
            r_data_col <= '0;
        end else if (r_state == S_SCAN) begin
            r_data_col <= r_issue[COL_W-1:0];
        end
        if (r_state == S_SCAN && r_data_vld) begin
            if (r_data_col == '0 || scan_val > r_best) begin
                r_best   <= scan_val;
                r_tie_n  <= CNT_W'(1);
                r_ties[0] <= r_data_col;
            end else if (scan_val == r_best) begin
                r_ties[r_tie_n[COL_W-1:0]] <= r_data_col;
                r_tie_n <= r_tie_n + CNT_W'(1);
            end
        end
        if (r_state == S_PICK && mod_rsp.done) begin
            r_res.explored <= r_explore;
            if (r_explore) begin
                r_res.action <= 3'(pick_idx);
            end else begin
                r_res.action <= 3'(r_ties[pick_idx]);
            end
        end
        if (out_load) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* dv/testbench.sv */
// self-checking testbench for the epsilon-greedy action selector
module testbench;
    import egas_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic signed [VALUE_W-1:0] value_store [TABLE_DEPTH] = '{default: '0};
    logic [EPS_W-1:0]          eps_pct = EPSILON_RESET;
    logic [AC_W-1:0]           act_cnt = ACTIONS_RESET;
    t_out_item                 pending_actions [$];
    t_out_item                 oldest;
    bit                        idle_on = 1'b1;
    int                        mismatch_cnt = 0;
    int                        quiet_cycles = 0;

    epsilon_greedy_action_select uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 18);
    end

    // updates the value store for a write, returns 1 with the chosen action for a select
    function automatic bit predict_action(input t_in_item it, output t_out_item res);
        int row;
        int n;
        int tie_n;
        int i;
        int ties [NUM_ACTIONS];
        logic signed [VALUE_W-1:0] best;
        row = it.state_index % NUM_STATES;
        res = '0;
        if (it.kind == KIND_WRITE) begin
            if (it.action_index < NUM_ACTIONS)
                value_store[row * NUM_ACTIONS + it.action_index] = it.q_value;
            return 1'b0;
        end
        if (act_cnt == 0)
            n = 1;
        else if (act_cnt > NUM_ACTIONS)
            n = NUM_ACTIONS;
        else
            n = act_cnt;
        if (int'(it.rand_explore) % int'(PERCENT_BASE) < int'(eps_pct)) begin
            res.action = 3'(int'(it.rand_pick) % n);
            res.explored = 1'b1;
        end else begin
            best = value_store[row * NUM_ACTIONS];
            tie_n = 1;
            ties[0] = 0;
            for (i = 1; i < n; i++) begin
                if (value_store[row * NUM_ACTIONS + i] > best) begin
                    best = value_store[row * NUM_ACTIONS + i];
                    tie_n = 1;
                    ties[0] = i;
                end else if (value_store[row * NUM_ACTIONS + i] == best) begin
                    ties[tie_n] = i;
                    tie_n++;
                end
            end
            res.action = 3'(ties[int'(it.rand_pick) % tie_n]);
            res.explored = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_in_item make_item(input logic kind, input int row, input int col,
                                           input logic [31:0] q, input int rexp,
                                           input int rpick);
        t_in_item it;
        it.kind = kind;
        it.state_index = 4'(row);
        it.action_index = 3'(col);
        it.q_value = q;
        it.rand_explore = RAND_W'(rexp);
        it.rand_pick = RAND_W'(rpick);
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        logic [31:0] q;
        case ($urandom_range(6))
            0: q = 32'h0000_0000;
            1: q = 32'h0000_0001;
            2: q = 32'hFFFF_FFFF;
            3: q = 32'h7FFF_FFFF;
            4: q = 32'h8000_0000;
            5: q = 32'h0001_0000;
            default: q = $urandom();
        endcase
        it = make_item(($urandom_range(99) < 55) ? KIND_SELECT : KIND_WRITE,
                       ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15),
                       $urandom_range(7), q, $urandom_range(32767), $urandom_range(32767));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        t_out_item res;
        @(negedge i_clk);
        if (idle_on && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_action(it, res))
            pending_actions.push_back(res);
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_EPSILON)
            eps_pct = EPS_W'(val);
        else if (idx == CFG_ACTIONS)
            act_cnt = AC_W'(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch (%s): expected action %0d explored %0d, got action %0d explored %0d",
                     what, want.action, want.explored, got.action, got.explored);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_actions.size() == 0) begin
                report_mismatch("unexpected result", '0, o_out_item);
            end else begin
                oldest = pending_actions.pop_front();
                if (o_out_item.action !== oldest.action ||
                    o_out_item.explored !== oldest.explored)
                    report_mismatch("result", oldest, o_out_item);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_cleared_table();
        send_item(make_item(KIND_SELECT, 0, 0, 32'h0, 0, 32767));
        send_item(make_item(KIND_SELECT, 15, 7, 32'hFFFF_FFFF, 20, 32767));
        send_item(make_item(KIND_SELECT, 15, 0, 32'h0, 32767, 0));
        send_item(make_item(KIND_SELECT, 0, 0, 32'h0, 99, 5));
    endtask

    task automatic test_value_extremes();
        send_item(make_item(KIND_WRITE, 15, 7, 32'h7FFF_FFFF, 32767, 32767));
        send_item(make_item(KIND_WRITE, 15, 0, 32'h8000_0000, 32767, 0));
        send_item(make_item(KIND_SELECT, 15, 7, 32'hFFFF_FFFF, 50, 32767));
        send_item(make_item(KIND_WRITE, 15, 7, 32'h8000_0000, 0, 32767));
        send_item(make_item(KIND_SELECT, 15, 0, 32'h0, 50, 32767));
        send_item(make_item(KIND_WRITE, 0, 3, 32'h0000_0001, 0, 0));
        send_item(make_item(KIND_WRITE, 0, 6, 32'h0000_0001, 0, 0));
        send_item(make_item(KIND_SELECT, 0, 3, 32'h7FFF_FFFF, 32767, 1));
        send_item(make_item(KIND_WRITE, 0, 0, 32'hFFFF_FFFF, 0, 0));
        send_item(make_item(KIND_SELECT, 0, 0, 32'h0, 19, 32767));
        send_item(make_item(KIND_SELECT, 0, 0, 32'h0, 99, 0));
        send_item(make_item(KIND_WRITE, 0, 3, 32'h7FFF_FFFF, 0, 0));
        send_item(make_item(KIND_SELECT, 0, 0, 32'h0, 100, 5));
        send_item(make_item(KIND_SELECT, 0, 0, 32'h0, 120, 32766));
    endtask

    task automatic test_config_extremes();
        int eps_set [7] = '{0, 127, 100, 101, 99, 0, 1};
        int cnt_set [7] = '{1, 0, 15, 9, 8, 2, 5};
        for (int k = 0; k < 7; k++) begin
            drain_block();
            write_reg(CFG_EPSILON, eps_set[k]);
            write_reg(CFG_ACTIONS, cnt_set[k]);
            repeat (12) send_item(rand_item());
        end
    endtask

    task automatic test_random_traffic();
        int eps;
        for (int phase = 0; phase < 8; phase++) begin
            drain_block();
            case ($urandom_range(5))
                0: eps = 0;
                1: eps = 127;
                2: eps = 100;
                default: eps = $urandom_range(0, 60);
            endcase
            write_reg(CFG_EPSILON, eps);
            write_reg(CFG_ACTIONS, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                            : $urandom_range(1, 8));
            idle_on = (phase != 1);
            for (int j = 0; j < 60; j++) begin
                if (phase == 4 && j == 30)
                    drain_block();
                send_item(rand_item());
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_table();
        test_value_extremes();
        test_config_extremes();
        test_random_traffic();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_actions.size() != 0)
            mismatch_cnt += pending_actions.size();
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
